@@ hdl/stq_pkg.sv @@
// Shared constants, types and command word format for the sorted timer queue.
package stq_pkg;

    localparam int DEPTH     = 64;
    localparam int TIME_BITS = 32;
    localparam int HANDLES   = 64;
    localparam int ID_BITS   = 6;
    localparam int AW        = $clog2(DEPTH);
    localparam int CW        = $clog2(DEPTH + 1);

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [ID_BITS-1:0]   t_id;
    typedef logic [AW-1:0]        t_addr;
    typedef logic [CW-1:0]        t_count;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_ADJUST = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;
    localparam logic [1:0] KIND_TICK   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_DUP    = 2'd3;

    typedef enum logic [2:0] {
        OP_INS,
        OP_DEL,
        OP_ADJ,
        OP_TICK,
        OP_REPORT
    } t_op;

    typedef struct packed {
        t_op        op;
        t_id        id;
        t_time      tval;
        logic [1:0] status;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_id  id;
    } t_pop;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SHIFT,
        S_POST,
        S_INS,
        S_INSCHK,
        S_PLACE,
        S_TICK
    } t_bstate;

endpackage

@@ hdl/stq_fifo.sv @@
// Two-word command queue between the front classifier and the back engine.
module stq_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  stq_pkg::t_cmd i_data,
    input  logic          i_pop,
    output stq_pkg::t_cmd o_data,
    output logic          o_empty,
    output logic          o_full
);

    stq_pkg::t_cmd r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

@@ hdl/stq_front.sv @@
// Front end: takes commands, checks handle presence and fill, queues work words.
module stq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_kind,
    input  logic [5:0]    i_timer_id,
    input  logic [31:0]   i_expire_time,
    input  logic [31:0]   i_now,
    input  logic          i_q_full,
    input  stq_pkg::t_pop i_pop,
    input  logic          i_tick_done,
    output logic          o_push,
    output stq_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    logic [stq_pkg::HANDLES-1:0] r_present;
    stq_pkg::t_count             r_cnt;
    logic                        r_tick_pend;
    logic                        accept;
    logic                        hit;

    assign o_busy = i_q_full | r_tick_pend;
    assign accept = i_start & ~o_busy;
    assign o_push = accept;
    assign hit    = r_present[i_timer_id];

    always_comb begin
        o_cmd.id     = i_timer_id;
        o_cmd.tval   = stq_pkg::TIME_BITS'(i_expire_time);
        o_cmd.status = stq_pkg::ST_OK;
        o_cmd.op     = stq_pkg::OP_REPORT;
        case (i_kind)
            stq_pkg::KIND_ADD: begin
                if (hit) begin
                    o_cmd.status = stq_pkg::ST_DUP;
                end else if (r_cnt == stq_pkg::CW'(stq_pkg::DEPTH)) begin
                    o_cmd.status = stq_pkg::ST_FULL;
                end else begin
                    o_cmd.op = stq_pkg::OP_INS;
                end
            end
            stq_pkg::KIND_ADJUST: begin
                if (hit) begin
                    o_cmd.op = stq_pkg::OP_ADJ;
                end else begin
                    o_cmd.status = stq_pkg::ST_ABSENT;
                end
            end
            stq_pkg::KIND_DELETE: begin
                if (hit) begin
                    o_cmd.op = stq_pkg::OP_DEL;
                end else begin
                    o_cmd.status = stq_pkg::ST_ABSENT;
                end
            end
            default: begin
                o_cmd.op   = stq_pkg::OP_TICK;
                o_cmd.tval = stq_pkg::TIME_BITS'(i_now);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= '0;
            r_cnt       <= '0;
            r_tick_pend <= 1'b0;
        end else begin
            if (accept && o_cmd.op == stq_pkg::OP_INS) begin
                r_present[i_timer_id] <= 1'b1;
                r_cnt                 <= r_cnt + 1'b1;
            end
            if (accept && o_cmd.op == stq_pkg::OP_DEL) begin
                r_present[i_timer_id] <= 1'b0;
                r_cnt                 <= r_cnt - 1'b1;
            end
            if (accept && o_cmd.op == stq_pkg::OP_TICK) begin
                r_tick_pend <= 1'b1;
            end
            if (i_pop.valid) begin
                r_present[i_pop.id] <= 1'b0;
                r_cnt               <= r_cnt - 1'b1;
            end
            if (i_tick_done) begin
                r_tick_pend <= 1'b0;
            end
        end
    end

endmodule

@@ hdl/stq_back.sv @@
// Back end: sorted slot memory with insert, remove and expiry pop sequencer.
module stq_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  stq_pkg::t_cmd i_q_data,
    output logic          o_q_pop,
    output stq_pkg::t_pop o_pop,
    output logic          o_tick_done,
    output logic          o_valid,
    output logic [1:0]    o_status,
    output logic          o_fired,
    output logic [5:0]    o_fired_id,
    output logic          o_last
);

    stq_pkg::t_time mem_exp [stq_pkg::DEPTH];
    stq_pkg::t_id   mem_id  [stq_pkg::DEPTH];

    stq_pkg::t_bstate r_state, n_state;
    stq_pkg::t_cmd    r_cmd, n_cmd;
    stq_pkg::t_addr   r_idx, n_idx;
    stq_pkg::t_count  r_cnt, n_cnt;
    logic             r_pend, n_pend;
    stq_pkg::t_id     r_pend_id, n_pend_id;
    stq_pkg::t_time   r_rd_exp;
    stq_pkg::t_id     r_rd_id;
    logic             r_valid, n_valid;
    logic [1:0]       r_status, n_status;
    logic             r_fired, n_fired;
    stq_pkg::t_id     r_fid, n_fid;
    logic             r_last, n_last;

    logic             rd_en, wr_en;
    stq_pkg::t_addr   rd_addr, wr_addr;
    stq_pkg::t_time   wr_exp;
    stq_pkg::t_id     wr_id;
    stq_pkg::t_count  idx_c;
    logic             found, more1, more2, due;

    assign idx_c = stq_pkg::CW'(r_idx);
    assign found = (r_rd_id == r_cmd.id);
    assign more1 = (idx_c + 1'b1) < r_cnt;
    assign more2 = (idx_c + 2'd2) < r_cnt;
    assign due   = (r_cnt != '0) && (r_rd_exp <= r_cmd.tval);

    always_comb begin
        n_state = r_state;
        case (r_state)
            stq_pkg::S_IDLE: begin
                if (!i_q_empty) begin
                    case (i_q_data.op)
                        stq_pkg::OP_REPORT: n_state = stq_pkg::S_IDLE;
                        stq_pkg::OP_TICK:   n_state = stq_pkg::S_TICK;
                        stq_pkg::OP_INS:    n_state = stq_pkg::S_INS;
                        default:            n_state = stq_pkg::S_FIND;
                    endcase
                end
            end
            stq_pkg::S_FIND: begin
                if (found) begin
                    n_state = more1 ? stq_pkg::S_SHIFT : stq_pkg::S_POST;
                end
            end
            stq_pkg::S_SHIFT: begin
                if (!more2) begin
                    n_state = stq_pkg::S_POST;
                end
            end
            stq_pkg::S_POST: begin
                case (r_cmd.op)
                    stq_pkg::OP_ADJ:  n_state = stq_pkg::S_INS;
                    stq_pkg::OP_TICK: n_state = stq_pkg::S_TICK;
                    default:          n_state = stq_pkg::S_IDLE;
                endcase
            end
            stq_pkg::S_INS: begin
                n_state = (r_cnt == '0) ? stq_pkg::S_IDLE : stq_pkg::S_INSCHK;
            end
            stq_pkg::S_INSCHK: begin
                if (r_rd_exp > r_cmd.tval) begin
                    if (r_idx == stq_pkg::AW'(1)) begin
                        n_state = stq_pkg::S_PLACE;
                    end
                end else begin
                    n_state = stq_pkg::S_IDLE;
                end
            end
            stq_pkg::S_PLACE: begin
                n_state = stq_pkg::S_IDLE;
            end
            stq_pkg::S_TICK: begin
                if (due) begin
                    n_state = (stq_pkg::CW'(1) < r_cnt) ? stq_pkg::S_SHIFT : stq_pkg::S_POST;
                end else begin
                    n_state = stq_pkg::S_IDLE;
                end
            end
            default: n_state = stq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_pend_id   = r_pend_id;
        n_valid     = 1'b0;
        n_status    = stq_pkg::ST_OK;
        n_fired     = 1'b0;
        n_fid       = '0;
        n_last      = 1'b1;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_exp      = r_cmd.tval;
        wr_id       = r_cmd.id;
        o_q_pop     = 1'b0;
        o_pop.valid = 1'b0;
        o_pop.id    = r_rd_id;
        o_tick_done = 1'b0;
        case (r_state)
            stq_pkg::S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_data;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    rd_en   = 1'b1;
                    if (i_q_data.op == stq_pkg::OP_REPORT) begin
                        n_valid  = 1'b1;
                        n_status = i_q_data.status;
                    end
                end
            end
            stq_pkg::S_FIND: begin
                rd_en = 1'b1;
                if (found) begin
                    rd_addr = r_idx + 1'b1;
                    if (!more1) begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    rd_addr = r_idx + 1'b1;
                end
            end
            stq_pkg::S_SHIFT: begin
                wr_en   = 1'b1;
                wr_exp  = r_rd_exp;
                wr_id   = r_rd_id;
                n_idx   = r_idx + 1'b1;
                rd_en   = 1'b1;
                rd_addr = r_idx + 2'd2;
                if (!more2) begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            stq_pkg::S_POST: begin
                rd_en = 1'b1;
                if (r_cmd.op == stq_pkg::OP_DEL) begin
                    n_valid = 1'b1;
                end
            end
            stq_pkg::S_INS: begin
                if (r_cnt == '0) begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    n_cnt   = r_cnt + 1'b1;
                    n_valid = 1'b1;
                end else begin
                    n_idx   = stq_pkg::AW'(r_cnt);
                    rd_en   = 1'b1;
                    rd_addr = stq_pkg::AW'(r_cnt - 1'b1);
                end
            end
            stq_pkg::S_INSCHK: begin
                wr_en = 1'b1;
                if (r_rd_exp > r_cmd.tval) begin
                    wr_exp  = r_rd_exp;
                    wr_id   = r_rd_id;
                    n_idx   = r_idx - 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = r_idx - 2'd2;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_valid = 1'b1;
                end
            end
            stq_pkg::S_PLACE: begin
                wr_en   = 1'b1;
                n_cnt   = r_cnt + 1'b1;
                n_valid = 1'b1;
            end
            stq_pkg::S_TICK: begin
                if (r_pend) begin
                    n_valid = 1'b1;
                    n_fired = 1'b1;
                    n_fid   = r_pend_id;
                    n_last  = ~due;
                end
                if (due) begin
                    n_pend      = 1'b1;
                    n_pend_id   = r_rd_id;
                    o_pop.valid = 1'b1;
                    n_idx       = '0;
                    rd_en       = 1'b1;
                    rd_addr     = stq_pkg::AW'(1);
                    if (!(stq_pkg::CW'(1) < r_cnt)) begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end else begin
                    o_tick_done = 1'b1;
                    if (!r_pend) begin
                        n_valid = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_exp[wr_addr] <= wr_exp;
            mem_id[wr_addr]  <= wr_id;
        end
        if (rd_en) begin
            r_rd_exp <= mem_exp[rd_addr];
            r_rd_id  <= mem_id[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_idx     <= n_idx;
        r_pend_id <= n_pend_id;
        r_status  <= n_status;
        r_fired   <= n_fired;
        r_fid     <= n_fid;
        r_last    <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stq_pkg::S_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_fired    = r_fired;
    assign o_fired_id = r_fid;
    assign o_last     = r_last;

endmodule

@@ hdl/sorted_timer_queue.sv @@
// Sorted timer queue top level: front classifier, command queue, sorted back engine.
// Commands are taken when start is high and busy is low; up to two may wait in the
// queue. After a tick, busy stays high until its last result is on the ports. Each
// result shows for one cycle with o_valid and cannot be held off. An add answers
// once its slot is placed, shifting later slots up; a delete answers after the
// search and the shift of the slots behind it; an adjust deletes, then re-inserts.
// A tick pops the head once per expired timer, with one result each (one result if
// none has expired), the last with o_last set.
module sorted_timer_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [5:0]  i_timer_id,
    input  logic [31:0] i_expire_time,
    input  logic [31:0] i_now,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic        o_fired,
    output logic [5:0]  o_fired_id,
    output logic        o_last
);

    logic          push;
    logic          q_pop;
    logic          q_empty;
    logic          q_full;
    logic          tick_done;
    stq_pkg::t_cmd f_cmd;
    stq_pkg::t_cmd q_cmd;
    stq_pkg::t_pop pop;

    stq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_kind       (i_kind),
        .i_timer_id   (i_timer_id),
        .i_expire_time(i_expire_time),
        .i_now        (i_now),
        .i_q_full     (q_full),
        .i_pop        (pop),
        .i_tick_done  (tick_done),
        .o_push       (push),
        .o_cmd        (f_cmd),
        .o_busy       (busy)
    );

    stq_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (f_cmd),
        .i_pop  (q_pop),
        .o_data (q_cmd),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    stq_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_data   (q_cmd),
        .o_q_pop    (q_pop),
        .o_pop      (pop),
        .o_tick_done(tick_done),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_fired    (o_fired),
        .o_fired_id (o_fired_id),
        .o_last     (o_last)
    );

endmodule
